FILE: rtl/rcw_pkg.sv
`default_nettype none
package rcw_pkg;

    localparam int TS_W   = 48;
    localparam int WND_W  = 16;
    localparam int INC_W  = 32;
    localparam int SES_W  = 8;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 24;
    localparam int NUM_SESSIONS = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_MTU       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TO    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TO    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SSL   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SSL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_WND  = 3'd5;

    localparam logic REQ_ACK   = 1'b0;
    localparam logic REQ_CHECK = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [SES_W-1:0]  session;
        logic [TS_W-1:0]   now_ts;
        logic [TS_W-1:0]   sent_ts;
        logic [WND_W-1:0]  peer_window;
    } in_item_t;

    typedef struct packed {
        logic [SES_W-1:0]  session_out;
        logic [WND_W-1:0]  window;
        logic [WND_W-1:0]  slow_start_limit;
        logic [TS_W-1:0]   timeout;
        logic              resend;
        logic              window_collapsed;
    } out_item_t;

    // classified work handed from front to back
    typedef struct packed {
        logic              req_type;
        logic [SES_W-1:0]  session;
        logic [TS_W-1:0]   elapsed;
        logic              was_sent;
        logic [WND_W-1:0]  peer_window;
    } work_t;

    typedef struct packed {
        logic [15:0] mtu;
        logic [23:0] min_to;
        logic [23:0] max_to;
        logic [15:0] min_ssl;
        logic [15:0] init_ssl;
        logic [15:0] init_wnd;
    } cfg_t;

endpackage
`default_nettype wire

FILE: rtl/rcw_front.sv
`default_nettype none
module rcw_front
    import rcw_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          q_valid,
    input  wire logic     q_stall,
    output work_t         q_data
);
    // two-entry queue
    work_t    q_mem [2];
    logic     wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic     push, pop;
    work_t    w;

    always_comb
    begin
        w.req_type    = in_data.req_type;
        w.session     = in_data.session;
        w.elapsed     = in_data.now_ts - in_data.sent_ts;
        w.was_sent    = (in_data.sent_ts != '0);
        w.peer_window = in_data.peer_window;
    end

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign pop      = q_valid && !q_stall;
    assign q_data   = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= w;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rcw_div.sv
`default_nettype none
module rcw_div
    import rcw_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [INC_W-1:0] dividend,
    input  wire logic [INC_W-1:0] divisor,
    output logic                  done,
    output logic [INC_W-1:0]      quotient
);
    // restoring divider, one bit a cycle
    logic [INC_W-1:0] q_reg, q_next;
    logic [INC_W-1:0] r_reg, r_next;
    logic [INC_W-1:0] d_reg, d_next;
    logic [5:0]       n_reg, n_next;
    logic             busy_reg, busy_next, done_reg, done_next;
    logic [INC_W:0]   trial;

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        n_next = n_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial = {r_reg, q_reg[INC_W-1]} ;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            n_next = 6'(INC_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                trial = trial - {1'b0, d_reg};
                q_next = {q_reg[INC_W-2:0], 1'b1};
            end
            else
            begin
                q_next = {q_reg[INC_W-2:0], 1'b0};
            end
            r_next = trial[INC_W-1:0];
            n_next = n_reg - 6'd1;
            if (n_reg == 6'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign done = done_reg;
    assign quotient = q_reg;

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_reg    <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            n_reg    <= n_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rcw_back.sv
`default_nettype none
module rcw_back
    import rcw_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_t      cfg,
    input  wire logic      q_valid,
    output logic           q_stall,
    input  wire work_t     q_data,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_RD    = 4'd1;
    localparam logic [3:0] ST_LOAD  = 4'd2;
    localparam logic [3:0] ST_EST1  = 4'd3;
    localparam logic [3:0] ST_EST2  = 4'd4;
    localparam logic [3:0] ST_GROW  = 4'd5;
    localparam logic [3:0] ST_DIV1  = 4'd6;
    localparam logic [3:0] ST_DIV2  = 4'd7;
    localparam logic [3:0] ST_CA    = 4'd8;
    localparam logic [3:0] ST_WR    = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;
    localparam logic [3:0] ST_MUL   = 4'd11;

    localparam logic [INC_W-1:0] INC_MAX = '1;
    localparam logic [WND_W-1:0] WND_MAX = '1;

    logic [3:0] st_reg, st_next;

    logic [WND_W-1:0] wnd_mem [NUM_SESSIONS];
    logic [WND_W-1:0] thr_mem [NUM_SESSIONS];
    logic [INC_W-1:0] inc_mem [NUM_SESSIONS];
    logic [NUM_SESSIONS-1:0] sv_reg;
    logic [WND_W-1:0] wnd_rd_reg, thr_rd_reg;
    logic [INC_W-1:0] inc_rd_reg;

    work_t            wk_reg;
    logic [SES_W-1:0] s_idx;
    logic [TS_W-1:0]  srtt_reg, var_reg, rto_reg;
    logic [TS_W+2:0]  srtt_tmp_reg;
    logic [TS_W+2:0]  var_tmp_reg;
    logic [WND_W-1:0] w_reg;
    logic [WND_W-1:0] t_reg;
    logic [INC_W-1:0] inc_reg;
    logic [INC_W-1:0] mm_reg;
    logic             resend_reg, coll_reg;
    out_item_t        out_reg;
    logic             out_valid_reg;
    logic             out_take;

    logic [15:0]      m;
    logic             div_start, div_done;
    logic [INC_W-1:0] div_a, div_b, div_q;
    logic [INC_W:0]   inc_m;

    assign m = (cfg.mtu == '0) ? 16'd1 : cfg.mtu;
    assign s_idx = wk_reg.session;
    assign inc_m = {1'b0, inc_reg} + {17'd0, m};
    assign out_take = (st_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    rcw_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_stall   = (st_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // memory read, write-back once peer cap and collapse have landed
    always_ff @(posedge clk)
    begin
        wnd_rd_reg <= wnd_mem[s_idx];
        thr_rd_reg <= thr_mem[s_idx];
        inc_rd_reg <= inc_mem[s_idx];
        if (out_take)
        begin
            wnd_mem[s_idx] <= w_reg;
            thr_mem[s_idx] <= t_reg;
            inc_mem[s_idx] <= inc_reg;
        end
    end

    logic [TS_W:0]    d_abs;
    logic [TS_W+2:0]  rto_sum;
    logic [TS_W-1:0]  rto_c;
    logic [INC_W:0]   sum33;
    logic [INC_W-1:0] init_inc;
    logic [WND_W-1:0] half;
    logic [INC_W:0]   chk;

    always_comb
    begin
        st_next   = st_reg;
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        d_abs     = '0;
        rto_sum   = '0;
        rto_c     = '0;
        sum33     = '0;
        init_inc  = '0;
        half      = '0;
        chk       = '0;
        init_inc  = {16'd0, cfg.init_wnd} * {16'd0, m};
        case (st_reg)
            ST_IDLE: if (q_valid) st_next = ST_RD;
            ST_RD:   st_next = ST_LOAD;
            ST_LOAD:
            begin
                if (wk_reg.req_type == REQ_ACK) st_next = ST_EST1;
                else st_next = ST_WR;
            end
            ST_EST1: st_next = ST_EST2;
            ST_EST2: st_next = ST_GROW;
            ST_GROW:
            begin
                if (w_reg < t_reg) st_next = ST_WR;
                else st_next = ST_MUL;
            end
            ST_MUL:
            begin
                div_start = 1'b1;
                div_a = mm_reg;
                div_b = inc_reg;
                st_next = ST_DIV1;
            end
            ST_DIV1: if (div_done) st_next = ST_DIV2;
            ST_DIV2:
            begin
                // ceil(inc / m), computed as (inc + m - 1) / m
                sum33 = {1'b0, inc_reg} + {17'd0, m} - 33'd1;
                div_start = 1'b1;
                div_a = (sum33 > {1'b0, INC_MAX}) ? INC_MAX : sum33[INC_W-1:0];
                div_b = {16'd0, m};
                st_next = ST_CA;
            end
            ST_CA:   if (div_done) st_next = ST_WR;
            ST_WR:   st_next = ST_OUT;
            ST_OUT:  if (!out_valid_reg || !out_stall) st_next = ST_IDLE;
            default: st_next = ST_IDLE;
        endcase
        d_abs = (wk_reg.elapsed >= srtt_reg) ? {1'b0, wk_reg.elapsed - srtt_reg}
                                             : {1'b0, srtt_reg - wk_reg.elapsed};
        rto_sum = {3'd0, srtt_reg} + {1'b0, var_reg, 2'b00};
        if (rto_sum < {27'd0, cfg.min_to}) rto_c = {24'd0, cfg.min_to};
        else rto_c = rto_sum[TS_W-1:0];
        if (rto_sum < {27'd0, cfg.min_to})
        begin
            if ({24'd0, cfg.min_to} > {24'd0, cfg.max_to}) rto_c = {24'd0, cfg.max_to};
        end
        else if (rto_sum > {27'd0, cfg.max_to}) rto_c = {24'd0, cfg.max_to};
        half = w_reg >> 1;
        chk = ({17'd0, w_reg} + 33'd1) * {17'd0, m};
    end

    logic [INC_W+4:0] ca_sum;
    assign ca_sum = {5'd0, inc_reg} + {5'd0, div_q} + {25'd0, m[15:4]};

    always_ff @(posedge clk)
    begin
        case (st_reg)
            ST_IDLE:
            begin
                wk_reg     <= q_data;
                resend_reg <= 1'b0;
                coll_reg   <= 1'b0;
            end
            ST_LOAD:
            begin
                if (!sv_reg[s_idx])
                begin
                    w_reg   <= cfg.init_wnd;
                    t_reg   <= cfg.init_ssl;
                    inc_reg <= init_inc;
                end
                else
                begin
                    w_reg   <= wnd_rd_reg;
                    t_reg   <= thr_rd_reg;
                    inc_reg <= inc_rd_reg;
                end
            end
            ST_EST1:
            begin
                if (srtt_reg == '0)
                begin
                    srtt_tmp_reg <= {3'd0, wk_reg.elapsed};
                    var_tmp_reg  <= {4'd0, wk_reg.elapsed[TS_W-1:1]};
                end
                else
                begin
                    var_tmp_reg  <= (({3'd0, var_reg} << 1) + {3'd0, var_reg}
                                     + {2'd0, d_abs}) >> 2;
                    srtt_tmp_reg <= (({3'd0, srtt_reg} << 3) - {3'd0, srtt_reg}
                                     + {3'd0, wk_reg.elapsed}) >> 3;
                end
            end
            ST_GROW:
            begin
                if (w_reg < t_reg)
                begin
                    w_reg <= w_reg + 16'd1;
                    inc_reg <= (inc_m > {1'b0, INC_MAX}) ? INC_MAX : inc_m[INC_W-1:0];
                end
                else
                begin
                    if (inc_reg < {16'd0, m}) inc_reg <= {16'd0, m};
                    mm_reg <= {16'd0, m} * {16'd0, m};
                end
            end
            ST_DIV1:
            begin
                if (div_done)
                begin
                    inc_reg <= (ca_sum > {5'd0, INC_MAX}) ? INC_MAX : ca_sum[INC_W-1:0];
                end
            end
            ST_CA:
            begin
                if (div_done && chk <= {1'b0, inc_reg})
                begin
                    w_reg <= (div_q > {16'd0, WND_MAX}) ? WND_MAX : div_q[WND_W-1:0];
                end
            end
            ST_WR:
            begin
                if (wk_reg.req_type == REQ_ACK)
                begin
                    if (wk_reg.peer_window < w_reg) w_reg <= wk_reg.peer_window;
                end
                else if (wk_reg.elapsed >= rto_reg)
                begin
                    resend_reg <= 1'b1;
                    if (wk_reg.was_sent)
                    begin
                        coll_reg <= 1'b1;
                        t_reg    <= (half > cfg.min_ssl) ? half : cfg.min_ssl;
                        w_reg    <= 16'd1;
                        inc_reg  <= {16'd0, m};
                    end
                end
            end
            default: ;
        endcase
        if (out_take)
        begin
            out_reg.session_out      <= wk_reg.session;
            out_reg.window           <= w_reg;
            out_reg.slow_start_limit <= t_reg;
            out_reg.timeout          <= rto_reg;
            out_reg.resend           <= resend_reg;
            out_reg.window_collapsed <= coll_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            sv_reg        <= '0;
            srtt_reg      <= '0;
            var_reg       <= '0;
            rto_reg       <= TS_W'(1000000);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (out_take)
            begin
                out_valid_reg <= 1'b1;
                sv_reg[s_idx] <= 1'b1;
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (st_reg == ST_EST2)
            begin
                srtt_reg <= (srtt_reg != '0 && srtt_tmp_reg == '0) ? TS_W'(1)
                                                                    : srtt_tmp_reg[TS_W-1:0];
                var_reg  <= var_tmp_reg[TS_W-1:0];
            end
            if (st_reg == ST_GROW && wk_reg.req_type == REQ_ACK)
            begin
                rto_reg <= rto_c;
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rto_and_congestion_window.sv
// Jacobson retransmit-timeout estimator with per-session congestion window.
// An ack or retransmit-check transaction is accepted into a two-entry queue
// and then carried out by a sequencer one at a time; one result transaction
// per input. A check skips the estimator and window growth, an ack in slow
// start grows the window directly, and an ack in congestion avoidance runs
// two serial divisions; a stalled result holds the sequencer until taken.
`default_nettype none
module rto_and_congestion_window
    import rcw_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire in_item_t              in_data,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output out_item_t                  out_data
);
    cfg_t  cfg_reg;
    logic  q_valid, q_stall;
    work_t q_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mtu      <= 16'd4096;
            cfg_reg.min_to   <= 24'd1000;
            cfg_reg.max_to   <= 24'd1000000;
            cfg_reg.min_ssl  <= 16'd2;
            cfg_reg.init_ssl <= 16'd64;
            cfg_reg.init_wnd <= 16'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MTU:      cfg_reg.mtu      <= cfg_data[15:0];
                CFG_MIN_TO:   cfg_reg.min_to   <= cfg_data;
                CFG_MAX_TO:   cfg_reg.max_to   <= cfg_data;
                CFG_MIN_SSL:  cfg_reg.min_ssl  <= cfg_data[15:0];
                CFG_INIT_SSL: cfg_reg.init_ssl <= cfg_data[15:0];
                CFG_INIT_WND: cfg_reg.init_wnd <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    rcw_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .q_valid  (q_valid),
        .q_stall  (q_stall),
        .q_data   (q_data)
    );

    rcw_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_stall   (q_stall),
        .q_data    (q_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule
`default_nettype wire

FILE: rtl/rcw_checker.sv
`default_nettype none
module rcw_checker
    import rcw_pkg::*;
(
    input wire logic      clk,
    input wire logic      rst_n,
    input wire logic      out_valid,
    input wire logic      out_stall,
    input wire out_item_t out_data
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_ack_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.resend |-> !out_data.window_collapsed)
        else $error("collapse without resend");

    a_collapse_one: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.window_collapsed |-> out_data.window == 16'd1)
        else $error("collapsed window not one");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid in reset");
endmodule

bind rto_and_congestion_window rcw_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);
`default_nettype wire
